[hdl/tte_pkg.sv]
// tag tree encoder package: sizes, command and register codes, divider structs
// no dependencies
package tte_pkg;

    localparam int MAX_LEAVES    = 4096;
    localparam int NODE_DEPTH    = 8192;
    localparam int ADDR_W        = 13;
    localparam int MAX_LEVELS    = 8;
    localparam int LV_W          = 3;
    localparam int LVC_W         = 4;
    localparam int DIM_W         = 7;
    localparam int COORD_W       = 6;
    localparam int LEAF_W        = 12;
    localparam int VAL_W         = 16;
    localparam int THR_W         = 6;
    localparam int ACC_W         = 25;
    localparam int CFG_IDX_W     = 2;

    localparam logic [DIM_W-1:0] DIM_LIMIT     = 7'd64;
    localparam logic [THR_W-1:0] MAX_THRESHOLD = 6'd48;
    localparam logic [VAL_W-1:0] UNSET_VALUE   = 16'hFFFF;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_ENCODE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAVES_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVES_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVES_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVES_T = 2'd3;

    typedef struct packed {
        logic              start;
        logic [LEAF_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [LEAF_W-1:0] quotient;
        logic [DIM_W-1:0]  remainder;
    } t_div_rsp;

endpackage

[hdl/tte_ifaces.sv]
// valid/ready channel interfaces of the tag tree encoder
// depends on tte_pkg
interface tte_in_if import tte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [LEAF_W-1:0] leaf_num;
    logic [VAL_W-1:0]  leaf_value;
    logic [THR_W-1:0]  code_threshold;
    logic              estimate_only;
    modport source (output valid, command, leaf_num, leaf_value, code_threshold,
                    estimate_only, input ready);
    modport sink (input valid, command, leaf_num, leaf_value, code_threshold,
                  estimate_only, output ready);
endinterface

interface tte_out_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic last_bit;
    logic no_bits;
    modport source (output valid, code_bit, last_bit, no_bits, input ready);
    modport sink (input valid, code_bit, last_bit, no_bits, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/tag_tree_encoder_4d_unit.sv]
// top level of the four-dimensional tag tree encoder: sequencer, node memories
// depends on tte_pkg, tte_ifaces, tte_div
//
// usage:
//   i_in  : one command per transfer (clear, set leaf value, encode leaf)
//   i_cfg : leaf counts per dimension, index 0..3; always ready, used at clear
//   o_out : one transfer per emitted tag tree bit; the final one of an encode
//           carries last_bit, an encode with no bit gives one no_bits transfer
// command flow:
//   clear : per tree level a multiply chain through the shared multiplier and a
//           size check, then a clearing pass over all 8192 nodes, one per cycle
//   set   : the leaf index division, then per level walked an index
//           multiply-add chain and a memory read
//   encode: the division, then per level the index chain, a memory read and
//           the bit loop, which a stalled receiver can hold
// one command is in work at a time; i_in.ready is low until it is done
// reset: runs the clearing pass, then leaves no tree built until a clear
// a stalled receiver holds the sequencer at the next bit; one bit waits in
// the output register while the following one is formed
module tag_tree_encoder_4d_unit import tte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tte_in_if.sink    i_in,
    tte_cfg_if.sink   i_cfg,
    tte_out_if.source o_out
);
    // sequencer codes
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SWEEP = 5'd1;
    localparam logic [4:0] S_B_M0  = 5'd2;
    localparam logic [4:0] S_B_M1  = 5'd3;
    localparam logic [4:0] S_B_M2  = 5'd4;
    localparam logic [4:0] S_B_M3  = 5'd5;
    localparam logic [4:0] S_B_CHK = 5'd6;
    localparam logic [4:0] S_DS    = 5'd7;
    localparam logic [4:0] S_DW    = 5'd8;
    localparam logic [4:0] S_I0    = 5'd9;
    localparam logic [4:0] S_I1    = 5'd10;
    localparam logic [4:0] S_I2    = 5'd11;
    localparam logic [4:0] S_I3    = 5'd12;
    localparam logic [4:0] S_I4    = 5'd13;
    localparam logic [4:0] S_RD    = 5'd14;
    localparam logic [4:0] S_SET   = 5'd15;
    localparam logic [4:0] S_ELD   = 5'd16;
    localparam logic [4:0] S_BIT   = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    logic [4:0] r_state;

    // configuration registers
    logic [DIM_W-1:0] r_cfg_x, r_cfg_y, r_cfg_z, r_cfg_t;

    // level layout
    logic [ADDR_W-1:0] r_off [MAX_LEVELS];
    logic [DIM_W-1:0]  r_nx  [MAX_LEVELS];
    logic [DIM_W-1:0]  r_ny  [MAX_LEVELS];
    logic [DIM_W-1:0]  r_nz  [MAX_LEVELS];
    logic [DIM_W-1:0]  r_nt  [MAX_LEVELS];
    logic [LVC_W-1:0]  r_lvl_cnt;
    logic [ADDR_W-1:0] r_leaf_cnt;

    // tree build
    logic [DIM_W-1:0] r_bx, r_by, r_bz, r_bt;
    logic [LVC_W-1:0] r_n;
    logic [ACC_W-1:0] r_total;
    logic [ACC_W-1:0] w_total_nxt;

    // shared multiply-add unit
    logic [ACC_W-1:0] r_acc;
    logic [DIM_W-1:0] w_mul_a, w_add_b;
    logic [31:0]      w_mac;

    // command
    logic [1:0]        r_cmd;
    logic [LEAF_W-1:0] r_dq;
    logic [VAL_W-1:0]  r_val;
    logic [THR_W-1:0]  r_thr;
    logic              r_est;
    logic [1:0]        r_dstep;
    logic [COORD_W-1:0] r_cx, r_cy, r_cz, r_ct;
    logic [LV_W-1:0]   r_lv;

    // encode walk
    logic [VAL_W-1:0] r_v;
    logic [THR_W-1:0] r_tt, r_tmin;
    logic             r_pend_v, r_pend_bit;
    logic             w_more;
    logic [THR_W-1:0] w_tt_inc;

    // output register
    logic r_out_valid, r_out_bit, r_out_last, r_out_nob;
    logic w_can_load;
    logic w_out_load, w_out_bit, w_out_last, w_out_nob;

    // node memories
    logic [VAL_W-1:0]  r_val_mem [NODE_DEPTH];
    logic [THR_W-1:0]  r_thr_mem [NODE_DEPTH];
    logic [ADDR_W-1:0] r_addr;
    logic [VAL_W-1:0]  r_rd_val;
    logic [THR_W-1:0]  r_rd_thr;
    logic              w_val_we, w_thr_we;
    logic [VAL_W-1:0]  w_val_wd;
    logic [THR_W-1:0]  w_thr_wd;

    // divider
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic w_in_fire;

    tte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = d;
        if (d == '0) c = 7'd1;
        else if (d > DIM_LIMIT) c = DIM_LIMIT;
        return c;
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= 7'd1;
            r_cfg_y <= 7'd1;
            r_cfg_z <= 7'd1;
            r_cfg_t <= 7'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEAVES_X: r_cfg_x <= i_cfg.data;
                CFG_LEAVES_Y: r_cfg_y <= i_cfg.data;
                CFG_LEAVES_Z: r_cfg_z <= i_cfg.data;
                CFG_LEAVES_T: r_cfg_t <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // operand select for the multiply-add unit
    always_comb begin
        w_mul_a = '0;
        w_add_b = '0;
        case (r_state)
            S_B_M1: w_mul_a = r_by;
            S_B_M2: w_mul_a = r_bz;
            S_B_M3: w_mul_a = r_bt;
            S_I1: begin
                w_mul_a = r_nz[r_lv];
                w_add_b = {1'b0, r_cz >> r_lv};
            end
            S_I2: begin
                w_mul_a = r_ny[r_lv];
                w_add_b = {1'b0, r_cy >> r_lv};
            end
            S_I3: begin
                w_mul_a = r_nx[r_lv];
                w_add_b = {1'b0, r_cx >> r_lv};
            end
            default: ;
        endcase
    end

    assign w_mac       = 32'(r_acc) * 32'(w_mul_a) + 32'(w_add_b);
    assign w_total_nxt = r_total + r_acc;

    // bit loop condition and output register availability
    assign w_more     = (r_v >= 16'(r_tt)) && (r_tt < r_thr);
    assign w_tt_inc   = r_tt + 6'd1;
    assign w_can_load = !r_out_valid || o_out.ready;

    // divider request
    always_comb begin
        w_div_req.start    = (r_state == S_DS);
        w_div_req.dividend = r_dq;
        case (r_dstep)
            2'd0:    w_div_req.divisor = r_nx[0];
            2'd1:    w_div_req.divisor = r_ny[0];
            default: w_div_req.divisor = r_nz[0];
        endcase
    end

    // memory write controls
    always_comb begin
        w_val_we = 1'b0;
        w_thr_we = 1'b0;
        w_val_wd = r_val;
        w_thr_wd = r_tt;
        case (r_state)
            S_SWEEP: begin
                w_val_we = 1'b1;
                w_thr_we = 1'b1;
                w_val_wd = UNSET_VALUE;
                w_thr_wd = '0;
            end
            S_SET: begin
                w_val_we = !((r_lv != '0) && (r_rd_val <= r_val));
            end
            S_BIT: begin
                w_thr_we = !w_more && !r_est;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_val_mem[r_addr] <= w_val_wd;
        end
        r_rd_val <= r_val_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_thr_we) begin
            r_thr_mem[r_addr] <= w_thr_wd;
        end
        r_rd_thr <= r_thr_mem[r_addr];
    end

    // output register load: a held bit once the next one exists, or the final transfer
    always_comb begin
        w_out_load = 1'b0;
        w_out_bit  = r_pend_bit;
        w_out_last = 1'b0;
        w_out_nob  = 1'b0;
        case (r_state)
            S_BIT: w_out_load = w_more && r_pend_v && w_can_load;
            S_FIN: begin
                w_out_load = w_can_load;
                w_out_bit  = r_pend_v && r_pend_bit;
                w_out_last = 1'b1;
                w_out_nob  = !r_pend_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
            r_out_bit   <= w_out_bit;
            r_out_last  <= w_out_last;
            r_out_nob   <= w_out_nob;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_addr      <= '0;
            r_lvl_cnt   <= '0;
            r_leaf_cnt  <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_cmd <= i_in.command;
                        r_dq  <= i_in.leaf_num;
                        r_val <= i_in.leaf_value;
                        r_thr <= (i_in.code_threshold > MAX_THRESHOLD) ?
                                 MAX_THRESHOLD : i_in.code_threshold;
                        r_est <= i_in.estimate_only;
                        r_dstep <= 2'd0;
                        case (i_in.command)
                            CMD_CLEAR: begin
                                r_bx    <= clamp_dim(r_cfg_x);
                                r_by    <= clamp_dim(r_cfg_y);
                                r_bz    <= clamp_dim(r_cfg_z);
                                r_bt    <= clamp_dim(r_cfg_t);
                                r_n     <= '0;
                                r_total <= '0;
                                r_state <= S_B_M0;
                            end
                            CMD_SET: begin
                                if ({1'b0, i_in.leaf_num} < r_leaf_cnt) begin
                                    r_state <= S_DS;
                                end
                            end
                            CMD_ENCODE: begin
                                // leaf out of range gives the no-bit result
                                r_state <= ({1'b0, i_in.leaf_num} < r_leaf_cnt) ?
                                           S_DS : S_FIN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWEEP: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(NODE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_B_M0: begin
                    r_acc   <= ACC_W'(r_bx);
                    r_state <= S_B_M1;
                end
                S_B_M1: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_B_M2;
                end
                S_B_M2: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_B_M3;
                end
                S_B_M3: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_B_CHK;
                end
                S_B_CHK: begin
                    r_addr <= '0;
                    if (r_n == LVC_W'(MAX_LEVELS) ||
                        (r_n == '0 && r_acc > ACC_W'(MAX_LEAVES)) ||
                        w_total_nxt > ACC_W'(NODE_DEPTH)) begin
                        // tree too large: no tree, nodes still cleared
                        r_lvl_cnt  <= '0;
                        r_leaf_cnt <= '0;
                        r_state    <= S_SWEEP;
                    end else begin
                        r_off[r_n[LV_W-1:0]] <= r_total[ADDR_W-1:0];
                        r_nx[r_n[LV_W-1:0]]  <= r_bx;
                        r_ny[r_n[LV_W-1:0]]  <= r_by;
                        r_nz[r_n[LV_W-1:0]]  <= r_bz;
                        r_nt[r_n[LV_W-1:0]]  <= r_bt;
                        r_total <= w_total_nxt;
                        if (r_n == '0) begin
                            r_leaf_cnt <= r_acc[ADDR_W-1:0];
                        end
                        if (r_acc == ACC_W'(1)) begin
                            r_lvl_cnt <= r_n + 1'b1;
                            r_state   <= S_SWEEP;
                        end else begin
                            r_bx    <= DIM_W'((r_bx + 7'd1) >> 1);
                            r_by    <= DIM_W'((r_by + 7'd1) >> 1);
                            r_bz    <= DIM_W'((r_bz + 7'd1) >> 1);
                            r_bt    <= DIM_W'((r_bt + 7'd1) >> 1);
                            r_n     <= r_n + 1'b1;
                            r_state <= S_B_M0;
                        end
                    end
                end
                S_DS: begin
                    r_state <= S_DW;
                end
                S_DW: begin
                    if (!w_div_rsp.busy) begin
                        r_dq <= w_div_rsp.quotient;
                        case (r_dstep)
                            2'd0: r_cx <= w_div_rsp.remainder[COORD_W-1:0];
                            2'd1: r_cy <= w_div_rsp.remainder[COORD_W-1:0];
                            default: begin
                                r_cz <= w_div_rsp.remainder[COORD_W-1:0];
                                r_ct <= w_div_rsp.quotient[COORD_W-1:0];
                            end
                        endcase
                        if (r_dstep == 2'd2) begin
                            r_tmin  <= '0;
                            r_lv    <= (r_cmd == CMD_SET) ? '0 :
                                       LV_W'(r_lvl_cnt - 1'b1);
                            r_state <= S_I0;
                        end else begin
                            r_dstep <= r_dstep + 2'd1;
                            r_state <= S_DS;
                        end
                    end
                end
                S_I0: begin
                    r_acc   <= ACC_W'(r_ct >> r_lv);
                    r_state <= S_I1;
                end
                S_I1: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_I2;
                end
                S_I2: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_I3;
                end
                S_I3: begin
                    r_acc   <= w_mac[ACC_W-1:0];
                    r_state <= S_I4;
                end
                S_I4: begin
                    r_addr  <= r_off[r_lv] + r_acc[ADDR_W-1:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= (r_cmd == CMD_SET) ? S_SET : S_ELD;
                end
                S_SET: begin
                    // stop once the parent already holds a value no larger
                    if ((r_lv != '0) && (r_rd_val <= r_val)) begin
                        r_state <= S_IDLE;
                    end else if (LVC_W'(r_lv) == r_lvl_cnt - 1'b1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lv    <= r_lv + 1'b1;
                        r_state <= S_I0;
                    end
                end
                S_ELD: begin
                    r_v     <= r_rd_val;
                    r_tt    <= (r_rd_thr < r_tmin) ? r_tmin : r_rd_thr;
                    r_state <= S_BIT;
                end
                S_BIT: begin
                    if (w_more) begin
                        // the held bit goes out once the next one exists
                        if (!r_pend_v || w_can_load) begin
                            r_pend_v   <= 1'b1;
                            r_pend_bit <= !(r_v >= 16'(w_tt_inc));
                            r_tt       <= w_tt_inc;
                        end
                    end else begin
                        r_tmin <= (r_v < 16'(r_tt)) ? r_v[THR_W-1:0] : r_tt;
                        if (r_lv == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_lv    <= r_lv - 1'b1;
                            r_state <= S_I0;
                        end
                    end
                end
                S_FIN: begin
                    if (w_can_load) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.code_bit = r_out_bit;
    assign o_out.last_bit = r_out_last;
    assign o_out.no_bits  = r_out_nob;

`ifndef NO_ASSERTIONS
    // no bit may be left held between commands
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held bit left over at idle");

    // level walk stays inside the built tree
    a_lv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_I0) |-> (LVC_W'(r_lv) < r_lvl_cnt))
        else $error("level index beyond level count");

    // thresholds never exceed the saturation limit
    a_tt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> (r_tt <= MAX_THRESHOLD))
        else $error("threshold above limit");

    // a walk only starts when a tree exists
    a_tree_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DS) |-> (r_lvl_cnt != '0))
        else $error("leaf walk without a tree");
`endif
endmodule

[hdl/tte_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on tte_pkg
module tte_div import tte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic              r_busy;
    logic [3:0]        r_cnt;
    logic [DIM_W-1:0]  r_rem;
    logic [LEAF_W-1:0] r_quo;
    logic [DIM_W-1:0]  r_d;
    logic [DIM_W:0]    w_sh;
    logic              w_ge;
    logic [DIM_W:0]    w_diff;

    assign w_sh   = {r_rem, r_quo[LEAF_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_d};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'(LEAF_W);
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_d    <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIM_W-1:0] : w_sh[DIM_W-1:0];
            r_quo <= {r_quo[LEAF_W-2:0], w_ge};
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
endmodule

[tb/tag_tree_encoder_4d_unit_tb.sv]
// testbench of the four-dimensional tag tree encoder: directed and random commands,
// results checked against a behavioral tree kept in the bench
// depends on tte_pkg, tte_ifaces and tag_tree_encoder_4d_unit
`timescale 1ns / 100ps

module tag_tree_encoder_4d_unit_tb;
    import tte_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic code_bit;
        logic last_bit;
        logic no_bits;
    } t_tag_bit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tte_in_if  in_if ();
    tte_cfg_if cfg_if ();
    tte_out_if out_if ();

    tag_tree_encoder_4d_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // behavioral copy of the tree
    logic [DIM_W-1:0] dim_reg [4];
    logic [VAL_W-1:0] node_val [NODE_DEPTH];
    logic [THR_W-1:0] node_thr [NODE_DEPTH];
    int               lvl_off [MAX_LEVELS];
    int               lvl_dim [MAX_LEVELS][4];
    int               lvl_cnt;

    t_tag_bit expected_bits [$];
    int       fail_count = 0;
    int       no_idle = 0;     // 1: neither side idles
    int       hold_req = 0;    // long receiver hold-off, in cycles
    bit       took_bit = 1'b0;

    // ---------------------------------------------------------------
    // tree model
    // ---------------------------------------------------------------
    function automatic int tree_leaves();
        if (lvl_cnt == 0) return 0;
        return lvl_dim[0][0] * lvl_dim[0][1] * lvl_dim[0][2] * lvl_dim[0][3];
    endfunction

    task automatic build_layout();
        int d [4];
        int total;
        int prod;
        int n;
        for (int i = 0; i < 4; i++) begin
            d[i] = (dim_reg[i] == 0) ? 1 : ((dim_reg[i] > DIM_LIMIT) ? DIM_LIMIT : dim_reg[i]);
        end
        lvl_cnt = 0;
        // too many leaves: no tree at all
        if (d[0] * d[1] * d[2] * d[3] > MAX_LEAVES) return;
        total = 0;
        n = 0;
        forever begin
            if (n >= MAX_LEVELS) return;
            prod = d[0] * d[1] * d[2] * d[3];
            lvl_off[n] = total;
            for (int i = 0; i < 4; i++) lvl_dim[n][i] = d[i];
            total += prod;
            if (total > NODE_DEPTH) return;
            if (prod == 1) break;
            for (int i = 0; i < 4; i++) d[i] = (d[i] + 1) >> 1;
            n++;
        end
        lvl_cnt = n + 1;
    endtask

    task automatic wipe_nodes();
        for (int i = 0; i < NODE_DEPTH; i++) begin
            node_val[i] = UNSET_VALUE;
            node_thr[i] = '0;
        end
    endtask

    // node on the path of leaf coordinates c at level lv
    function automatic int node_index(int lv, int c [4]);
        int idx;
        idx = (c[3] >> lv) * lvl_dim[lv][2] + (c[2] >> lv);
        idx = idx * lvl_dim[lv][1] + (c[1] >> lv);
        idx = idx * lvl_dim[lv][0] + (c[0] >> lv);
        return (lvl_off[lv] + idx) % NODE_DEPTH;
    endfunction

    task automatic predict_command(input logic [1:0] cmd, input logic [LEAF_W-1:0] leaf,
                                   input logic [VAL_W-1:0] val,
                                   input logic [THR_W-1:0] thr_in, input logic est);
        int c [4];
        int rest;
        int idx;
        int lv;
        int thr;
        int tmin;
        int v;
        int tt;
        t_tag_bit bits [$];
        t_tag_bit rec;
        if (cmd == CMD_CLEAR) begin
            build_layout();
            wipe_nodes();
        end else if (cmd == CMD_SET || cmd == CMD_ENCODE) begin
            if (leaf < tree_leaves()) begin
                rest = leaf;
                for (int i = 0; i < 3; i++) begin
                    c[i] = rest % lvl_dim[0][i];
                    rest = rest / lvl_dim[0][i];
                end
                c[3] = rest;
            end
            if (cmd == CMD_SET) begin
                if (leaf < tree_leaves()) begin
                    // carry the value up while it lowers the parent minimum
                    for (lv = 0; lv < lvl_cnt; lv++) begin
                        idx = node_index(lv, c);
                        if (lv > 0 && node_val[idx] <= val) break;
                        node_val[idx] = val;
                    end
                end
            end else begin
                thr = (thr_in > MAX_THRESHOLD) ? MAX_THRESHOLD : thr_in;
                if (leaf < tree_leaves()) begin
                    tmin = 0;
                    for (lv = lvl_cnt - 1; lv >= 0; lv--) begin
                        idx = node_index(lv, c);
                        v = node_val[idx];
                        tt = node_thr[idx];
                        if (tt < tmin) tt = tmin;
                        while (v >= tt && tt < thr) begin
                            tt++;
                            rec.code_bit = (v >= tt) ? 1'b0 : 1'b1;
                            rec.last_bit = 1'b0;
                            rec.no_bits = 1'b0;
                            bits.push_back(rec);
                        end
                        tmin = (v < tt) ? v : tt;
                        if (!est) node_thr[idx] = tt[THR_W-1:0];
                    end
                end
                if (bits.size() == 0) begin
                    rec.code_bit = 1'b0;
                    rec.last_bit = 1'b1;
                    rec.no_bits = 1'b1;
                    bits.push_back(rec);
                end
                bits[bits.size() - 1].last_bit = 1'b1;
                foreach (bits[i]) expected_bits.push_back(bits[i]);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // one command transfer; valid stays high when no gap follows
    task automatic send_cmd(input logic [1:0] cmd, input int leaf, input int val,
                            input int thr, input int est);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.command        <= cmd;
        in_if.leaf_num       <= leaf[LEAF_W-1:0];
        in_if.leaf_value     <= val[VAL_W-1:0];
        in_if.code_threshold <= thr[THR_W-1:0];
        in_if.estimate_only  <= est[0];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_command(cmd, leaf[LEAF_W-1:0], val[VAL_W-1:0], thr[THR_W-1:0], est[0]);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data[DIM_W-1:0];
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        dim_reg[idx] = data[DIM_W-1:0];
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // block idle: all bits in, command finished, plus a margin for trailing work
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        repeat (2) @(negedge i_clk);
        while (expected_bits.size() != 0 || !in_if.ready) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic set_dims(input int x, input int y, input int z, input int t);
        wait_idle();
        write_reg(CFG_LEAVES_X, x);
        write_reg(CFG_LEAVES_Y, y);
        write_reg(CFG_LEAVES_Z, z);
        write_reg(CFG_LEAVES_T, t);
    endtask

    // receiver: per transfer a random gap, or a long hold-off on request
    initial begin
        int gap;
        gap = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (took_bit) begin
                took_bit = 1'b0;
                gap = draw_gap();
            end
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end
            out_if.ready <= (gap == 0);
            if (gap > 0) gap--;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_tag_bit want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            took_bit = 1'b1;
            if (expected_bits.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: bit %0b last %0b none %0b",
                             out_if.code_bit, out_if.last_bit, out_if.no_bits);
            end else begin
                want = expected_bits.pop_front();
                if (want.code_bit !== out_if.code_bit || want.last_bit !== out_if.last_bit ||
                    want.no_bits !== out_if.no_bits) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp bit %0b last %0b none %0b, got %0b %0b %0b",
                                 want.code_bit, want.last_bit, want.no_bits,
                                 out_if.code_bit, out_if.last_bit, out_if.no_bits);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // nothing built after reset: set ignored, encode gives the empty result
    task automatic test_unbuilt_tree();
        send_cmd(CMD_ENCODE, 0, 0, 5, 0);
        send_cmd(CMD_SET, 0, 3, 0, 0);
        send_cmd(CMD_ENCODE, 0, 0, 48, 0);
        send_cmd(CMD_UNUSED, 0, 0, 0, 0);
    endtask

    task automatic test_small_tree();
        set_dims(3, 2, 1, 1);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        send_cmd(CMD_SET, 0, 3, 0, 0);
        send_cmd(CMD_SET, 5, 0, 0, 0);
        send_cmd(CMD_SET, 0, 1, 0, 0);          // overwrite with a lower value
        send_cmd(CMD_SET, 2, 65535, 0, 0);
        send_cmd(CMD_SET, 3, 65534, 0, 0);
        send_cmd(CMD_SET, 4, 9, 63, 1);
        send_cmd(CMD_ENCODE, 0, 0, 4, 0);
        send_cmd(CMD_ENCODE, 0, 0, 6, 0);       // resumes from stored thresholds
        send_cmd(CMD_ENCODE, 5, 0, 63, 0);      // threshold saturates
        send_cmd(CMD_ENCODE, 2, 0, 48, 1);      // estimate leaves thresholds alone
        send_cmd(CMD_ENCODE, 2, 0, 48, 0);
        send_cmd(CMD_ENCODE, 6, 0, 10, 0);      // leaf past the end
        send_cmd(CMD_SET, 4095, 0, 0, 0);
        send_cmd(CMD_ENCODE, 4095, 65535, 63, 1);
        send_cmd(CMD_ENCODE, 1, 0, 0, 0);       // zero threshold: no bits
        send_cmd(CMD_UNUSED, 1, 5, 5, 1);
        send_cmd(CMD_ENCODE, 4, 0, 48, 0);
    endtask

    // out-of-range register values and a tree with too many leaves
    task automatic test_dim_limits();
        set_dims(0, 127, 1, 1);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        send_cmd(CMD_SET, 63, 7, 0, 0);
        send_cmd(CMD_ENCODE, 63, 0, 10, 0);
        send_cmd(CMD_ENCODE, 64, 0, 10, 0);
        set_dims(64, 64, 1, 2);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        send_cmd(CMD_SET, 0, 1, 0, 0);
        send_cmd(CMD_ENCODE, 0, 0, 20, 0);
    endtask

    task automatic random_items(input int n);
        int r;
        int cnt;
        int leaf;
        int val;
        int thr;
        logic [1:0] cmd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            cnt = tree_leaves();
            if (r < 3) cmd = CMD_UNUSED;
            else if (r < 5) cmd = CMD_CLEAR;
            else if (r < 48) cmd = CMD_SET;
            else cmd = CMD_ENCODE;
            if ($urandom_range(0, 9) == 0 || cnt == 0) leaf = $urandom_range(0, 4095);
            else leaf = $urandom_range(0, cnt - 1);
            r = $urandom_range(0, 9);
            if (r < 5) val = $urandom_range(0, 50);
            else if (r < 7) val = $urandom_range(0, 65535);
            else if (r == 7) val = 0;
            else if (r == 8) val = 65535;
            else val = 65534;
            thr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 48) : $urandom_range(0, 63);
            send_cmd(cmd, leaf, val, thr, ($urandom_range(0, 3) == 0) ? 1 : 0);
        end
    endtask

    task automatic test_random_trees();
        int x;
        int y;
        int z;
        int t;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin x = 1;  y = 1;  z = 1;  t = 1;  end
                1: begin x = 64; y = 64; z = 1;  t = 1;  end
                2: begin x = 64; y = 1;  z = 1;  t = 64; end
                3: begin x = 2;  y = 3;  z = 5;  t = 7;  end
                4: begin x = 8;  y = 8;  z = 8;  t = 8;  end
                default: begin
                    x = $urandom_range(1, 64);
                    y = $urandom_range(1, 4096 / x > 64 ? 64 : 4096 / x);
                    z = $urandom_range(1, 4096 / (x * y) > 64 ? 64 : 4096 / (x * y));
                    t = $urandom_range(1, 4096 / (x * y * z) > 64 ? 64 : 4096 / (x * y * z));
                end
            endcase
            no_idle = (ph % 3 == 1);
            set_dims(x, y, z, t);
            send_cmd(CMD_CLEAR, 0, 0, 0, 0);
            random_items(45);
        end
        no_idle = 0;
    endtask

    // receiver stalls long while encodes keep coming
    task automatic test_output_stall();
        set_dims(4, 4, 1, 1);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++) send_cmd(CMD_SET, i, 40 + i, 0, 0);
        no_idle = 1;
        hold_req = 400;
        for (int i = 0; i < 8; i++) send_cmd(CMD_ENCODE, i, 0, 48, 1);
        no_idle = 0;
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.command = CMD_CLEAR;
        in_if.leaf_num = '0;
        in_if.leaf_value = '0;
        in_if.code_threshold = '0;
        in_if.estimate_only = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_LEAVES_X;
        cfg_if.data = '0;
        for (int i = 0; i < 4; i++) dim_reg[i] = 7'd1;
        lvl_cnt = 0;
        wipe_nodes();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unbuilt_tree();
        test_small_tree();
        test_dim_limits();
        test_random_trees();
        test_output_stall();

        wait_idle();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/tte_pkg.sv
hdl/tte_ifaces.sv
hdl/tte_div.sv
hdl/tag_tree_encoder_4d_unit.sv
tb/tag_tree_encoder_4d_unit_tb.sv
